// File: rtl/mrpt_pkg.sv
// Shared types for the Miller-Rabin witness-round block.
// Used by mrpt_ctrl, mrpt_dp and miller_rabin_primality_test; no dependencies.
package mrpt_pkg;

    localparam int INPUT_WIDTH = 32;
    localparam int DIV_BITS    = 32;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STRIP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_POW_INIT,
        CMD_MUL_AB,
        CMD_MUL_BB,
        CMD_MUL_XX,
        CMD_SHIFT_E,
        CMD_SQ_INIT,
        CMD_INC_I
    } t_cmd;

    typedef struct packed {
        logic fail_direct;
        logic pass_direct;
        logic d_lsb;
        logic div_last;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
        logic x_one;
        logic x_last;
        logic sq_more;
    } t_status;

endpackage

// File: rtl/mrpt_dp.sv
// Datapath: operand registers, bit-serial remainder unit and bit-serial
// modular multiplier. Depends on mrpt_pkg.
module mrpt_dp #(
    parameter int NW = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mrpt_pkg::t_cmd               i_cmd,
    input  logic [mrpt_pkg::INPUT_WIDTH-1:0] i_candidate,
    input  logic [mrpt_pkg::DIV_BITS-1:0]    i_random_word,
    output mrpt_pkg::t_status            o_status
);
    localparam int SW = $clog2(NW + 1);
    localparam int MW = (NW > 1) ? $clog2(NW) : 1;
    localparam int DW = $clog2(mrpt_pkg::DIV_BITS);

    logic [NW-1:0] r_n, r_d, r_rem, r_base, r_acc, r_mx, r_my, r_macc, r_divisor;
    logic [SW-1:0] r_s, r_i;
    logic [mrpt_pkg::DIV_BITS-1:0] r_q;
    logic [DW-1:0] r_div_cnt;
    logic [MW-1:0] r_mcnt;
    logic          r_mbusy, r_mdone, r_mdest_base;

    logic [NW:0]   t_dbl, t_add, t_rem;
    logic [NW-1:0] dbl_red, add_red, mul_next, rem_next;

    // one step of the double-and-add multiply and one step of the serial remainder
    always_comb begin
        t_dbl   = {r_macc, 1'b0};
        dbl_red = (t_dbl >= {1'b0, r_n}) ? NW'(t_dbl - {1'b0, r_n}) : t_dbl[NW-1:0];
        t_add   = {1'b0, dbl_red} + {1'b0, r_mx};
        add_red = (t_add >= {1'b0, r_n}) ? NW'(t_add - {1'b0, r_n}) : t_add[NW-1:0];
        mul_next = r_my[NW-1] ? add_red : dbl_red;
        t_rem    = {r_rem, r_q[mrpt_pkg::DIV_BITS-1]};
        rem_next = (t_rem >= {1'b0, r_divisor}) ? NW'(t_rem - {1'b0, r_divisor})
                                                : t_rem[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (r_mbusy) begin
                r_macc <= mul_next;
                r_my   <= r_my << 1;
                r_mcnt <= r_mcnt + 1'b1;
                if (r_mcnt == MW'(NW - 1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                    if (r_mdest_base) r_base <= mul_next;
                    else              r_acc  <= mul_next;
                end
            end
            unique case (i_cmd) inside
                mrpt_pkg::CMD_LOAD: begin
                    r_n <= i_candidate[NW-1:0];
                    r_d <= i_candidate[NW-1:0] - 1'b1;
                    r_q <= i_random_word;
                    r_s <= '0;
                end
                mrpt_pkg::CMD_STRIP: begin
                    r_d <= r_d >> 1;
                    r_s <= r_s + 1'b1;
                end
                mrpt_pkg::CMD_DIV_INIT: begin
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_divisor <= r_n - NW'(4);
                end
                mrpt_pkg::CMD_DIV_STEP: begin
                    r_rem     <= rem_next;
                    r_q       <= r_q << 1;
                    r_div_cnt <= r_div_cnt + 1'b1;
                end
                mrpt_pkg::CMD_POW_INIT: begin
                    r_base <= r_rem + NW'(2);
                    r_acc  <= NW'(1);
                end
                mrpt_pkg::CMD_MUL_AB, mrpt_pkg::CMD_MUL_BB, mrpt_pkg::CMD_MUL_XX: begin
                    r_mbusy      <= 1'b1;
                    r_mcnt       <= '0;
                    r_macc       <= '0;
                    r_mdest_base <= (i_cmd == mrpt_pkg::CMD_MUL_BB);
                    r_mx         <= (i_cmd == mrpt_pkg::CMD_MUL_AB) ? r_acc :
                                    (i_cmd == mrpt_pkg::CMD_MUL_BB) ? r_base : r_acc;
                    r_my         <= (i_cmd == mrpt_pkg::CMD_MUL_XX) ? r_acc : r_base;
                end
                mrpt_pkg::CMD_SHIFT_E: r_d <= r_d >> 1;
                mrpt_pkg::CMD_SQ_INIT: r_i <= SW'(1);
                mrpt_pkg::CMD_INC_I:   r_i <= r_i + 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.fail_direct = (r_n <= NW'(1)) || (r_n == NW'(4))
                             || ((r_n > NW'(4)) && !r_n[0]);
        o_status.pass_direct = (r_n == NW'(2)) || (r_n == NW'(3));
        o_status.d_lsb       = r_d[0];
        o_status.div_last    = (r_div_cnt == DW'(mrpt_pkg::DIV_BITS - 1));
        o_status.mul_done    = r_mdone;
        o_status.e_zero      = (r_d == '0);
        o_status.e_lsb       = r_d[0];
        o_status.x_one       = (r_acc == NW'(1));
        o_status.x_last      = (r_acc == r_n - 1'b1);
        o_status.sq_more     = (r_i < r_s);
    end

endmodule

// File: rtl/mrpt_ctrl.sv
// Round sequencer: steps the datapath, keeps the composite flag and the
// result register. Depends on mrpt_pkg.
module mrpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_last_round,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_probably_prime,
    output mrpt_pkg::t_cmd    o_cmd,
    input  mrpt_pkg::t_status i_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_STRIP, S_DIV, S_POW_INIT, S_POW, S_WAIT_A, S_WAIT_B,
        S_TEST, S_SQ, S_WAIT_X, S_SQ_CHK, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_last, r_pass, n_pass, r_composite, r_valid, r_prime;

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_valid;
    assign o_probably_prime = r_prime;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = mrpt_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd   = mrpt_pkg::CMD_LOAD;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                if (i_status.fail_direct) begin
                    n_pass = 1'b0; n_state = S_FINISH;
                end else if (i_status.pass_direct) begin
                    n_pass = 1'b1; n_state = S_FINISH;
                end else n_state = S_STRIP;
            end
            S_STRIP: begin
                if (!i_status.d_lsb) o_cmd = mrpt_pkg::CMD_STRIP;
                else begin
                    o_cmd   = mrpt_pkg::CMD_DIV_INIT;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd = mrpt_pkg::CMD_DIV_STEP;
                if (i_status.div_last) n_state = S_POW_INIT;
            end
            S_POW_INIT: begin
                o_cmd   = mrpt_pkg::CMD_POW_INIT;
                n_state = S_POW;
            end
            S_POW: begin
                if (i_status.e_zero) n_state = S_TEST;
                else if (i_status.e_lsb) begin
                    o_cmd = mrpt_pkg::CMD_MUL_AB; n_state = S_WAIT_A;
                end else begin
                    o_cmd = mrpt_pkg::CMD_MUL_BB; n_state = S_WAIT_B;
                end
            end
            S_WAIT_A: if (i_status.mul_done) begin
                o_cmd = mrpt_pkg::CMD_MUL_BB; n_state = S_WAIT_B;
            end
            S_WAIT_B: if (i_status.mul_done) begin
                o_cmd = mrpt_pkg::CMD_SHIFT_E; n_state = S_POW;
            end
            S_TEST: begin
                if (i_status.x_one || i_status.x_last) begin
                    n_pass = 1'b1; n_state = S_FINISH;
                end else begin
                    o_cmd = mrpt_pkg::CMD_SQ_INIT; n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (!i_status.sq_more) begin
                    n_pass = 1'b0; n_state = S_FINISH;
                end else begin
                    o_cmd = mrpt_pkg::CMD_MUL_XX; n_state = S_WAIT_X;
                end
            end
            S_WAIT_X: if (i_status.mul_done) begin
                o_cmd = mrpt_pkg::CMD_INC_I; n_state = S_SQ_CHK;
            end
            S_SQ_CHK: begin
                if (i_status.x_last) begin
                    n_pass = 1'b1; n_state = S_FINISH;
                end else if (i_status.x_one) begin
                    n_pass = 1'b0; n_state = S_FINISH;
                end else n_state = S_SQ;
            end
            S_FINISH: begin
                // a last round's verdict waits here until the result register is free
                if (!r_last || !r_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_composite <= 1'b0;
            r_valid     <= 1'b0;
            r_prime     <= 1'b0;
            r_pass      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            if (r_state == S_IDLE && i_valid) r_last <= i_last_round;
            if (r_state == S_FINISH && r_last && (!r_valid || i_ready)) begin
                r_valid     <= 1'b1;
                r_prime     <= !(r_composite | !r_pass);
                r_composite <= 1'b0;
            end else begin
                if (r_valid && i_ready) r_valid <= 1'b0;
                if (r_state == S_FINISH && !r_last)
                    r_composite <= r_composite | !r_pass;
            end
        end
    end

endmodule

// File: rtl/miller_rabin_primality_test.sv
// Miller-Rabin witness-round unit. Each request is one round for candidate n;
// after a round marked last, one verdict (1 = probably prime) is produced and
// the composite flag clears. With n-1 = 2^s*d and W the data width (at most
// 32), a serial remainder over the random word picks the witness, then each
// modular product takes the W multiplier bits one bit per cycle on a shared
// double-and-add unit; a set bit of d costs two products, a clear bit one,
// and each squaring step is followed by a check. Only one round is in
// flight; the verdict is held in an output register and a last round waits
// while it is still occupied.
module miller_rabin_primality_test #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_random_word,
    input  logic        i_last_round,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_probably_prime
);
    localparam int NW = (NUMBER_WIDTH < mrpt_pkg::INPUT_WIDTH) ? NUMBER_WIDTH
                                                               : mrpt_pkg::INPUT_WIDTH;

    mrpt_pkg::t_cmd    cmd;
    mrpt_pkg::t_status status;

    mrpt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_last_round     (i_last_round),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_probably_prime (o_probably_prime),
        .o_cmd            (cmd),
        .i_status         (status)
    );

    mrpt_dp #(.NW(NW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_candidate   (i_candidate),
        .i_random_word (i_random_word),
        .o_status      (status)
    );

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while a round is in progress");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.mul_done |=> !status.mul_done)
        else $error("multiplier completion lasted more than one cycle");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == mrpt_pkg::CMD_LOAD) |-> o_ready)
        else $error("operands loaded outside idle");
`endif

endmodule

// File: tb/sv/mrpt_checker.sv
// Checker for miller_rabin_primality_test: watches both channels, predicts
// each verdict from the accepted rounds and compares. Depends on nothing else.
module mrpt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_random_word,
    input  logic        i_last_round,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic        i_probably_prime,
    input  logic        i_done,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic verdict_q[$];
    logic composite_seen;
    bit   done_seen;

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] n);
        logic [127:0] prod;
        prod = a * b;
        return 64'(prod % n);
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] n);
        logic [63:0] acc;
        acc  = 1 % n;
        base = base % n;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, base, n);
            base = mul_mod(base, base, n);
            e    = e >> 1;
        end
        return acc;
    endfunction

    // true when this witness round fails to prove n composite
    function automatic bit witness_passes(logic [63:0] n, logic [63:0] rnd);
        logic [63:0] d, a, x;
        int          s;
        if (n <= 1 || n == 4) return 0;
        if (n <= 3) return 1;
        if (!n[0]) return 0;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        a = 2 + rnd % (n - 4);
        x = pow_mod(a, d, n);
        if (x == 1 || x == n - 1) return 1;
        for (int i = 1; i < s; i++) begin
            x = mul_mod(x, x, n);
            if (x == n - 1) return 1;
            if (x == 1) return 0;
        end
        return 0;
    endfunction

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        o_errors++;
    endtask

    initial begin
        o_errors       = 0;
        o_pending      = 0;
        composite_seen = 0;
        done_seen      = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                if (!witness_passes({32'd0, i_candidate}, {32'd0, i_random_word}))
                    composite_seen = 1;
                if (i_last_round) begin
                    verdict_q.push_back(!composite_seen);
                    composite_seen = 0;
                end
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (verdict_q.size() == 0)
                    report("verdict with no request outstanding");
                else if (i_probably_prime !== verdict_q[0]) begin
                    report($sformatf("probably_prime %b, expected %b",
                                     i_probably_prime, verdict_q[0]));
                    void'(verdict_q.pop_front());
                end else
                    void'(verdict_q.pop_front());
            end
            if (i_done && !done_seen) begin
                done_seen = 1;
                if (verdict_q.size() != 0)
                    report($sformatf("%0d verdicts never arrived", verdict_q.size()));
            end
        end
        o_pending = verdict_q.size();
    end
endmodule

// File: tb/sv/testbench.sv
// Top of the primality-test bench: clock, reset, request stimulus, response
// back-pressure and verdict. Depends on mrpt_checker and the RTL top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 4000;

    logic        i_clk, i_rst_n;
    logic        req_valid, req_ready;
    logic [31:0] req_candidate, req_random;
    logic        req_last;
    logic        rsp_valid, rsp_ready, rsp_prime;
    logic        done;
    int          errors, pending, idle_cycles;
    logic [7:0]  ready_pattern;
    int          cycle_cnt;

    logic [31:0] primes[] = '{32'd5, 32'd7, 32'd11, 32'd13, 32'd97, 32'd7919,
                              32'd65537, 32'd104729, 32'd998244353, 32'd1000000007,
                              32'd2147483647, 32'd4294967291};
    logic [31:0] pseudo[] = '{32'd561, 32'd1105, 32'd1729, 32'd2465, 32'd41041,
                              32'd3215031751, 32'd25, 32'd4294967295};

    miller_rabin_primality_test i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (req_valid),
        .o_ready         (req_ready),
        .i_candidate     (req_candidate),
        .i_random_word   (req_random),
        .i_last_round    (req_last),
        .o_valid         (rsp_valid),
        .i_ready         (rsp_ready),
        .o_probably_prime(rsp_prime)
    );

    mrpt_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .i_candidate     (req_candidate),
        .i_random_word   (req_random),
        .i_last_round    (req_last),
        .i_rsp_valid     (rsp_valid),
        .i_rsp_ready     (rsp_ready),
        .i_probably_prime(rsp_prime),
        .i_done          (done),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // send one request; called at a falling edge, returns at a falling edge.
    // Ready comes from a register, so its value at a falling edge holds
    // through the next rising edge.
    task automatic send_round(logic [31:0] cand, logic [31:0] rnd, logic last,
                              int gap);
        req_valid     <= 1;
        req_candidate <= cand;
        req_random    <= rnd;
        req_last      <= last;
        while (!req_ready) @(negedge i_clk);
        @(negedge i_clk);
        if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    int burst_left, gap_max;

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 7);
        return (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
    endfunction

    task automatic run_test(logic [31:0] cand, int rounds);
        for (int r = 0; r < rounds; r++)
            send_round(cand, $urandom, r == rounds - 1, next_gap());
    endtask

    function automatic logic [31:0] pick_candidate();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return primes[$urandom_range(0, primes.size() - 1)];
        if (sel < 60) return pseudo[$urandom_range(0, pseudo.size() - 1)];
        if (sel < 80) return $urandom | 32'd1;
        if (sel < 92) return $urandom_range(5, 999) | 32'd1;
        return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8);
    endfunction

    // response side back-pressure: ready steps through a random 8-bit pattern that is redrawn now and then
    always @(negedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 64 == 0)
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        rsp_ready <= ready_pattern[cycle_cnt % 8];
    end

    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int tests;
        req_valid     = 0;
        req_candidate = 0;
        req_random    = 0;
        req_last      = 0;
        rsp_ready     = 0;
        ready_pattern = 8'hff;
        cycle_cnt     = 0;
        idle_cycles   = 0;
        done          = 0;
        burst_left    = 0;
        gap_max       = 3;
        i_rst_n       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: trivial candidates, extremes, liar then failing witness
        send_round(32'd0, 32'd0, 1, next_gap());
        send_round(32'd1, 32'hffffffff, 1, next_gap());
        send_round(32'd2, 32'd0, 1, next_gap());
        send_round(32'd3, 32'hffffffff, 1, next_gap());
        send_round(32'd4, 32'd1, 1, next_gap());
        send_round(32'd6, 32'd3, 1, next_gap());
        send_round(32'hfffffffe, 32'h5a5a5a5a, 1, next_gap());
        send_round(32'd5, 32'd0, 1, next_gap());
        send_round(32'd9, 32'd0, 0, next_gap());
        send_round(32'd9, 32'hffffffff, 1, next_gap());
        send_round(32'd25, 32'd5, 1, next_gap());
        send_round(32'd25, 32'd5, 0, next_gap());
        send_round(32'd25, 32'd0, 1, next_gap());
        send_round(32'd561, 32'd0, 0, next_gap());
        send_round(32'd561, 32'h12345678, 0, next_gap());
        send_round(32'd561, 32'hffffffff, 1, next_gap());
        send_round(32'd4294967291, 32'hffffffff, 0, next_gap());
        send_round(32'd4294967291, 32'd0, 1, next_gap());
        send_round(32'hffffffff, 32'haaaaaaaa, 1, next_gap());
        send_round(32'd2147483647, 32'h55555555, 1, next_gap());

        // random tests of one to four rounds, or a single round with a random last flag; gap behaviour varied per phase
        tests = 0;
        while (tests < 200) begin
            if (tests % 25 == 0) gap_max = $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0)
                send_round(pick_candidate(), $urandom, $urandom_range(0, 1),
                           next_gap());
            else
                run_test(pick_candidate(), $urandom_range(1, 4));
            tests++;
        end
        req_valid <= 0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        done <= 1;
        @(negedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
